// ===== src/fcik_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcik_pkg
// Shared constants, register reset values and types for the four-cable
// inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package fcik_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int NUM_CABLES = 4;
	localparam int NUM_REGS   = 2 * NUM_CABLES;
	localparam int GUARD_BITS = 12;

	localparam int POS_W   = 16;
	localparam int DIFF_W  = 18;
	localparam int SQ1_W   = 33;
	localparam int SQ_W    = 34;
	localparam int RAD_W   = SQ_W + 2 * GUARD_BITS;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int DLT_W   = ROOT_W + 2;
	localparam int MAG_W   = ROOT_W + 1;
	localparam int RCP_W   = 32;
	localparam int PROD_W  = MAG_W + RCP_W;
	localparam int SHIFT   = FRAC_BITS + GUARD_BITS + 24;
	localparam int Q_W     = PROD_W + 1 - SHIFT;
	localparam int STEPS_W = 20;
	localparam int LAT     = 3 + ROOT_W + 3;

	localparam logic [DIFF_W-1:0]  HALF_W    = DIFF_W'(4 << FRAC_BITS);
	localparam logic [RCP_W-1:0]   RECIP_Q24 = 32'd3417826378;
	localparam logic [63:0]        OUT_MAX   = 64'd524287;
	localparam logic [63:0]        OUT_MIN_M = 64'd524288;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	localparam logic [CFG_W-1:0] RESET_VALS [NUM_REGS] = '{
		32'd3892373376, 32'd629158016,
		32'd427878272,  32'd629158016,
		32'd427825024,  32'd629157888,
		32'd3892320128, 32'd629157888
	};

	localparam logic CORNER_EAST  [NUM_CABLES] = '{1'b0, 1'b1, 1'b1, 1'b0};
	localparam logic CORNER_NORTH [NUM_CABLES] = '{1'b0, 1'b0, 1'b1, 1'b1};

	typedef struct packed {
		logic [RAD_W-1:0]        rad;
		logic [REM_W-1:0]        rem;
		logic [ROOT_W-1:0]       root;
		logic signed [POS_W-1:0] rest;
	} sqrt_bus_t;

endpackage

// ===== src/fcik_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcik_sqrt_cell
// One restoring square root step: brings down two radicand bits and
// resolves one root bit, registered toward the next cell.
// ----------------------------------------------------------------------------
module fcik_sqrt_cell
	import fcik_pkg::*;
(
	input  logic      clk,
	input  logic      en,
	input  sqrt_bus_t bus_in,
	output sqrt_bus_t bus_out
);

	logic [REM_W-1:0] part;
	logic [REM_W-1:0] trial;
	logic             fit;
	sqrt_bus_t        nxt;

	always_comb begin
		part  = {bus_in.rem[REM_W-3:0], bus_in.rad[RAD_W-1 -: 2]};
		trial = {bus_in.root, 2'b01};
		fit   = (part >= trial);
		nxt.rad  = {bus_in.rad[RAD_W-3:0], 2'b00};
		nxt.rem  = fit ? (part - trial) : part;
		nxt.root = {bus_in.root[ROOT_W-2:0], fit};
		nxt.rest = bus_in.rest;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_out <= nxt;
		end
	end

endmodule

// ===== src/fcik_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcik_lane
// Step count pipeline of one cable: offsets, squares, square root chain,
// length difference, reciprocal multiply, rounding and saturation.
// ----------------------------------------------------------------------------
module fcik_lane
	import fcik_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic                      east,
	input  logic                      north,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic signed [POS_W-1:0]   pos_z,
	input  logic [CFG_W-1:0]          anchor_xy,
	input  logic [CFG_W-1:0]          anchor_zl,
	output logic signed [STEPS_W-1:0] steps
);

	logic [DIFF_W-1:0] ax_e, ay_e, az_e, px_e, py_e, pz_e, xo, yo;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [POS_W-1:0]  rest_s1, rest_s2;
	logic signed [2*DIFF_W-1:0] px2, py2, pz2;
	logic [SQ1_W-1:0] sx_s2, sy_s2, sz_s2;
	logic [SQ_W-1:0]  sum;
	sqrt_bus_t chain [ROOT_W+1];
	logic [DLT_W-1:0] dlt;
	logic             neg_s4, neg_s5;
	logic [MAG_W-1:0] mag_s4;
	logic [PROD_W-1:0] prod, prod_s5;
	logic [PROD_W:0]  rnd;
	logic [63:0]      qw;
	logic signed [STEPS_W-1:0] st;

	always_comb begin
		ax_e = {{2{anchor_xy[31]}}, anchor_xy[31:16]};
		ay_e = {{2{anchor_xy[15]}}, anchor_xy[15:0]};
		az_e = {{2{anchor_zl[31]}}, anchor_zl[31:16]};
		px_e = {{2{pos_x[POS_W-1]}}, pos_x};
		py_e = {{2{pos_y[POS_W-1]}}, pos_y};
		pz_e = {{2{pos_z[POS_W-1]}}, pos_z};
		xo   = east  ? (px_e + HALF_W) : (px_e - HALF_W);
		yo   = north ? (py_e + HALF_W) : (py_e - HALF_W);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= ax_e - xo;
			dy_s1   <= ay_e - yo;
			dz_s1   <= az_e - pz_e;
			rest_s1 <= anchor_zl[15:0];
		end
	end

	always_comb begin
		px2 = dx_s1 * dx_s1;
		py2 = dy_s1 * dy_s1;
		pz2 = dz_s1 * dz_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2   <= px2[SQ1_W-1:0];
			sy_s2   <= py2[SQ1_W-1:0];
			sz_s2   <= pz2[SQ1_W-1:0];
			rest_s2 <= rest_s1;
		end
	end

	assign sum = {1'b0, sx_s2} + {1'b0, sy_s2} + {1'b0, sz_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			chain[0].rad  <= {sum, {(2*GUARD_BITS){1'b0}}};
			chain[0].rem  <= '0;
			chain[0].root <= '0;
			chain[0].rest <= rest_s2;
		end
	end

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		fcik_sqrt_cell u_cell (
			.clk     (clk),
			.en      (en),
			.bus_in  (chain[i]),
			.bus_out (chain[i+1])
		);
	end

	assign dlt = {{(DLT_W-POS_W-GUARD_BITS){chain[ROOT_W].rest[POS_W-1]}},
		chain[ROOT_W].rest, {GUARD_BITS{1'b0}}} - {2'b00, chain[ROOT_W].root};

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s4 <= dlt[DLT_W-1];
			mag_s4 <= dlt[DLT_W-1] ? MAG_W'(-dlt) : dlt[MAG_W-1:0];
		end
	end

	assign prod = PROD_W'(mag_s4) * PROD_W'(RECIP_Q24);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= prod;
			neg_s5  <= neg_s4;
		end
	end

	always_comb begin
		rnd = {1'b0, prod_s5} + ((PROD_W+1)'(1) << (SHIFT - 1));
		qw  = 64'(rnd[PROD_W:SHIFT]);
		if (neg_s5) begin
			st = (qw > OUT_MIN_M) ? STEPS_W'(OUT_MIN_M) : STEPS_W'(64'd0 - qw);
		end else begin
			st = (qw > OUT_MAX) ? STEPS_W'(OUT_MAX) : STEPS_W'(qw);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			steps <= st;
		end
	end

endmodule

// ===== src/four_cable_inverse_kinematics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_cable_inverse_kinematics
// Sled position to four cable step counts through a 29-cell square root
// chain per cable; one item per cycle sustained while the output is not
// stalled into the skid buffer. Reset loads the default anchors and clears
// all valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module four_cable_inverse_kinematics
	import fcik_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [47:0]          s_axis_tdata,  // pos_x, pos_y, pos_z
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [79:0]          m_axis_tdata   // steps_a, steps_b, steps_c, steps_d
);

	logic [CFG_W-1:0] regs_q [NUM_REGS];
	logic [LAT-1:0]   vld_q;
	logic             pipe_en;
	logic [79:0]      lane_data, out_q, skid_q;
	logic             out_v_q, skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= RESET_VALS[i];
		end else if (cfg_we) begin
			regs_q[cfg_addr] <= cfg_data;
		end
	end

	assign pipe_en       = !skid_v_q;
	assign s_axis_tready = pipe_en;

	for (genvar k = 0; k < NUM_CABLES; k++) begin : g_lane
		fcik_lane u_lane (
			.clk       (clk),
			.en        (pipe_en),
			.east      (CORNER_EAST[k]),
			.north     (CORNER_NORTH[k]),
			.pos_x     (s_axis_tdata[15:0]),
			.pos_y     (s_axis_tdata[31:16]),
			.pos_z     (s_axis_tdata[47:32]),
			.anchor_xy (regs_q[2*k]),
			.anchor_zl (regs_q[2*k+1]),
			.steps     (lane_data[k*STEPS_W +: STEPS_W])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_axis_tready) skid_v_q <= 1'b0;
		end else if (vld_q[LAT-1]) begin
			if (out_v_q && !m_axis_tready) skid_v_q <= 1'b1;
			else out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_axis_tready) out_q <= skid_q;
		end else if (vld_q[LAT-1]) begin
			if (out_v_q && !m_axis_tready) skid_q <= lane_data;
			else out_q <= lane_data;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid holds item without output");
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !m_axis_tready) |=> skid_v_q) else $error("skid item lost");
	a_accept_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_q[0]) else $error("accept not tracked");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and checking for the four-cable inverse kinematics pipeline.
// Streams sled positions under random bursts, gaps and output stalls, with
// one long output hold-off. Every step result is compared against an
// in-bench fixed-point prediction across several anchor settings.
// ----------------------------------------------------------------------------
module testbench;
	import fcik_pkg::*;

	typedef logic signed [STEPS_W-1:0] steps_t;
	typedef struct {
		steps_t st [NUM_CABLES];
	} steps_set_t;

	class step_scoreboard;
		logic [CFG_W-1:0] anchors [NUM_REGS];
		steps_set_t       pending [$];
		int               errors;

		function new();
			foreach (anchors[i]) anchors[i] = RESET_VALS[i];
			errors = 0;
		endfunction

		function automatic logic [63:0] int_sqrt(logic [63:0] n);
			logic [63:0] root;
			logic [63:0] bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (n >= root + bitv) begin
					n = n - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			return root;
		endfunction

		function automatic steps_t cable_count(int k, longint px, longint py, longint pz);
			longint    half, dx, dy, dz, len, dif;
			logic [63:0] sq, mag, q;
			logic [127:0] prod;
			logic [31:0] xy, zl;
			xy = anchors[2 * k];
			zl = anchors[2 * k + 1];
			half = longint'(4) << FRAC_BITS;
			dx = longint'($signed(xy[31:16])) - (px + (CORNER_EAST[k] ? half : -half));
			dy = longint'($signed(xy[15:0])) - (py + (CORNER_NORTH[k] ? half : -half));
			dz = longint'($signed(zl[31:16])) - pz;
			sq = dx * dx + dy * dy + dz * dz;
			len = longint'(int_sqrt(sq << (2 * GUARD_BITS)));
			dif = longint'($signed(zl[15:0])) * (longint'(1) << GUARD_BITS) - len;
			mag = (dif < 0) ? -dif : dif;
			prod = 128'(mag) * 128'(RECIP_Q24) + (128'd1 << (SHIFT - 1));
			q = 64'(prod >> SHIFT);
			if (dif < 0) return (q > OUT_MIN_M) ? steps_t'(-524288) : steps_t'(-longint'(q));
			return (q > OUT_MAX) ? steps_t'(524287) : steps_t'(q);
		endfunction

		function void note_position(logic [47:0] pos);
			steps_set_t e;
			for (int k = 0; k < NUM_CABLES; k++)
				e.st[k] = cable_count(k, $signed(pos[15:0]), $signed(pos[31:16]),
					$signed(pos[47:32]));
			pending.push_back(e);
		endfunction

		function void check_steps(logic [79:0] data);
			steps_set_t e;
			string names [NUM_CABLES] = '{"steps_a", "steps_b", "steps_c", "steps_d"};
			if (pending.size() == 0) begin
				$error("unexpected result %h", data);
				errors++;
				return;
			end
			e = pending.pop_front();
			for (int k = 0; k < NUM_CABLES; k++)
				if (data[k*STEPS_W +: STEPS_W] !== e.st[k]) begin
					$error("%s: expected %0d, got %0d", names[k], e.st[k],
						$signed(data[k*STEPS_W +: STEPS_W]));
					errors++;
				end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata;  // pos_x, pos_y, pos_z
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [79:0]          m_axis_tdata;  // steps_a, steps_b, steps_c, steps_d

	step_scoreboard sb;
	int             hold_cycles;
	int             burst_left;

	four_cable_inverse_kinematics uut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("testbench failed");
		$finish;
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) sb.note_position(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) sb.check_steps(m_axis_tdata);
	end

	// receiver stall pattern, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (burst_left > 0) begin
			burst_left <= burst_left - 1;
			m_axis_tready <= 1'b1;
		end else begin
			burst_left <= $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : 0;
			m_axis_tready <= $urandom_range(0, 2) != 0;
		end
	end

	task automatic send_position(logic [47:0] pos);
		s_axis_tdata  <= pos;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic pause_sender();
		s_axis_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	task automatic send_random(int count);
		int run;
		run = 0;
		for (int i = 0; i < count; i++) begin
			logic [47:0] pos;
			if (run == 0) begin
				run = $urandom_range(1, 30);
				if ($urandom_range(0, 2) != 0) pause_sender();
			end
			run--;
			case ($urandom_range(0, 3))
				0: pos = 48'({$urandom(), $urandom()});
				default: pos = {16'($signed($urandom_range(0, 12000)) - 16'sd1000),
					16'($signed($urandom_range(0, 16000)) - 16'sd8000),
					16'($signed($urandom_range(0, 16000)) - 16'sd8000)};
			endcase
			send_position(pos);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [CFG_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_addr <= CFG_IDX_W'(idx);
		cfg_data <= value;
		@(posedge clk);
		sb.anchors[idx] = value;
	endtask

	initial begin
		logic [15:0] edges [6];
		sb = new();
		edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0400, 16'hfc00};
		arst_n = 0;
		cfg_we = 0;
		cfg_addr = 0;
		cfg_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		m_axis_tready = 0;
		hold_cycles = 0;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 6; i++)
			send_position({edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6]});
		send_position({16'sd9600, 16'h0000, 16'h0000});
		send_position(48'h0);
		send_position({16'h7fff, 16'h7fff, 16'h7fff});
		send_position({16'h8000, 16'h8000, 16'h8000});
		s_axis_tvalid <= 1'b0;

		// long output hold-off while input keeps coming
		@(posedge clk);
		hold_cycles <= 200;
		send_random(150);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			for (int r = 0; r < NUM_REGS; r++)
				case (phase)
					0: write_reg(r, 32'hffff_ffff);
					1: write_reg(r, 32'h0000_0000);
					2: write_reg(r, r[0] ? 32'h8000_7fff : 32'h7fff_8000);
					default: write_reg(r, $urandom());
				endcase
			cfg_we <= 1'b0;
			send_random(phase == 3 ? 240 : 50);
			drain();
		end

		if (sb.errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
